// ===== hdl/pfi_pkg.sv =====
// pfi_pkg: shared widths, register codes and transaction types of the
// adc pulse finder and integrator; no dependencies
package pfi_pkg;

  // field widths
  localparam int SAMPLE_W   = 12;
  localparam int TH_W       = 12;
  localparam int WLEN_W     = 11;
  localparam int IDX_W      = 3;
  localparam int LEAD_W     = 10;
  localparam int WIDTH_W    = 11;
  localparam int INTEG_W    = 22;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  typedef logic [SAMPLE_W-1:0]   sample_t;
  typedef logic [TH_W-1:0]       th_t;
  typedef logic [WLEN_W-1:0]     wlen_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [LEAD_W-1:0]     lead_t;
  typedef logic [WIDTH_W-1:0]    width_t;
  typedef logic [INTEG_W-1:0]    integ_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // register indexes
  localparam cfg_idx_t REG_THRESHOLD     = 1'b0;
  localparam cfg_idx_t REG_WINDOW_LENGTH = 1'b1;

  // register reset values
  localparam th_t   TH_RESET   = 12'd100;
  localparam wlen_t WLEN_RESET = 11'd1024;

  // accumulator saturation limits
  localparam width_t WIDTH_MAX = 11'h7FF;
  localparam integ_t INTEG_MAX = 22'h3FFFFF;

  // live configuration
  typedef struct packed {
    th_t   threshold;
    wlen_t window_length;
  } cfg_t;

  // one result transaction
  typedef struct packed {
    logic   pulse_valid;
    logic   window_end;
    idx_t   pulse_index;
    lead_t  lead_index;
    width_t pulse_len;
    integ_t pulse_integral;
  } res_t;

endpackage

// ===== hdl/pfi_cfg_regs.sv =====
// pfi_cfg_regs: threshold and window length registers behind the write port
// depends on pfi_pkg
module pfi_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  pfi_pkg::cfg_idx_t  cfg_index,
  input  pfi_pkg::cfg_data_t cfg_data,
  output pfi_pkg::cfg_t      cfg
);

  pfi_pkg::cfg_t cfg_r;
  pfi_pkg::cfg_t cfg_nxt;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        pfi_pkg::REG_THRESHOLD: begin
          cfg_nxt.threshold = pfi_pkg::th_t'(cfg_data);
        end
        pfi_pkg::REG_WINDOW_LENGTH: begin
          cfg_nxt.window_length = pfi_pkg::wlen_t'(cfg_data);
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold     <= pfi_pkg::TH_RESET;
      cfg_r.window_length <= pfi_pkg::WLEN_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/pfi_in_reg.sv =====
// pfi_in_reg: input register of the sample channel
// depends on pfi_pkg
module pfi_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  pfi_pkg::sample_t in_sample,
  input  logic             out_free,
  output logic             step_en,
  output pfi_pkg::sample_t sample
);

  logic             valid_r;
  logic             valid_nxt;
  pfi_pkg::sample_t sample_r;
  logic             accept;

  // the held sample moves on whenever the result side has room
  assign step_en  = valid_r && out_free;
  assign in_stall = valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (step_en) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_sample;
    end
  end

  assign sample = sample_r;

endmodule

// ===== hdl/pfi_core.sv =====
// pfi_core: pulse finder state and the single-pass step for one sample
// depends on pfi_pkg
module pfi_core #(
  parameter int MAX_PULSES = 8,
  parameter int MAX_WINDOW = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  pfi_pkg::sample_t sample,
  input  pfi_pkg::cfg_t    cfg,
  output logic             res_valid,
  output pfi_pkg::res_t    res
);

  localparam int POS_W  = $clog2(MAX_WINDOW);
  localparam int SLOT_W = $clog2(MAX_PULSES + 1);
  localparam int CW     = ((POS_W > pfi_pkg::WLEN_W) ? POS_W : pfi_pkg::WLEN_W) + 1;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CW-1:0]     cmp_t;

  pos_t            pos_r, pos_nxt;
  slot_t           slot_r, slot_nxt;
  pfi_pkg::idx_t   kept_r, kept_nxt;
  logic            in_pulse_r, in_pulse_nxt;
  logic            run_r, run_nxt;
  logic [1:0]      low_r, low_nxt;
  pfi_pkg::integ_t integ_r, integ_nxt;
  pfi_pkg::width_t width_r, width_nxt;
  pos_t            lead_r, lead_nxt;

  logic                      hi;
  logic                      lo;
  logic                      active;
  logic                      last;
  logic                      have;
  logic [1:0]                low_inc;
  logic [pfi_pkg::INTEG_W:0] integ_sum;
  cmp_t                      wlen_ext;
  cmp_t                      eff;
  cmp_t                      pos_inc;

  // sample classification against threshold and threshold minus one
  assign hi = sample >= cfg.threshold;
  assign lo = ({1'b0, sample} + 13'd1) < {1'b0, cfg.threshold};

  assign active    = slot_r < slot_t'(MAX_PULSES);
  assign integ_sum = {1'b0, integ_r} +
                     {{(pfi_pkg::INTEG_W + 1 - pfi_pkg::SAMPLE_W){1'b0}}, sample};
  assign low_inc   = (low_r < 2'd2) ? low_r + 2'd1 : low_r;

  // effective window length clamped to 2..MAX_WINDOW
  assign wlen_ext = cmp_t'(cfg.window_length);
  always_comb begin
    if (wlen_ext < cmp_t'(2)) begin
      eff = cmp_t'(2);
    end else if (wlen_ext > cmp_t'(MAX_WINDOW)) begin
      eff = cmp_t'(MAX_WINDOW);
    end else begin
      eff = wlen_ext;
    end
  end

  assign pos_inc = cmp_t'(pos_r) + cmp_t'(1);
  assign last    = pos_inc >= eff;

  // one step of the pulse finder
  always_comb begin
    pos_nxt      = pos_r;
    slot_nxt     = slot_r;
    kept_nxt     = kept_r;
    in_pulse_nxt = in_pulse_r;
    run_nxt      = run_r;
    low_nxt      = low_r;
    integ_nxt    = integ_r;
    width_nxt    = width_r;
    lead_nxt     = lead_r;
    have         = 1'b0;
    res          = '0;

    if (active) begin
      // high sample extends the pulse
      if (hi) begin
        if (!run_r) begin
          in_pulse_nxt = 1'b1;
          lead_nxt     = pos_r;
          run_nxt      = 1'b1;
        end
        low_nxt   = 2'd0;
        integ_nxt = (integ_sum > {1'b0, pfi_pkg::INTEG_MAX}) ?
                    pfi_pkg::INTEG_MAX : integ_sum[pfi_pkg::INTEG_W-1:0];
        if (width_r != pfi_pkg::WIDTH_MAX) begin
          width_nxt = width_r + pfi_pkg::width_t'(1);
        end
      end
      // low sample, the second since the last high one closes the pulse
      if (lo) begin
        low_nxt = low_inc;
        if (in_pulse_r && (low_inc == 2'd2)) begin
          if (width_r > pfi_pkg::width_t'(1)) begin
            have                 = 1'b1;
            res.pulse_valid      = 1'b1;
            res.pulse_index      = kept_r;
            res.lead_index       = pfi_pkg::lead_t'(lead_r);
            res.pulse_len        = width_r;
            res.pulse_integral   = integ_r;
            kept_nxt             = kept_r + pfi_pkg::idx_t'(1);
          end
          slot_nxt     = slot_r + slot_t'(1);
          in_pulse_nxt = 1'b0;
          integ_nxt    = '0;
          width_nxt    = '0;
          lead_nxt     = '0;
        end
        run_nxt = 1'b0;
      end
    end

    if (last) begin
      // report a still open pulse, then restart the window
      if (!have && in_pulse_nxt && (width_nxt > pfi_pkg::width_t'(1))) begin
        res.pulse_valid    = 1'b1;
        res.pulse_index    = kept_nxt;
        res.lead_index     = pfi_pkg::lead_t'(lead_nxt);
        res.pulse_len      = width_nxt;
        res.pulse_integral = integ_nxt;
      end
      res.window_end = 1'b1;
      pos_nxt        = '0;
      slot_nxt       = '0;
      kept_nxt       = '0;
      in_pulse_nxt   = 1'b0;
      run_nxt        = 1'b0;
      low_nxt        = 2'd0;
      integ_nxt      = '0;
      width_nxt      = '0;
      lead_nxt       = '0;
    end else begin
      pos_nxt = pos_t'(pos_inc);
    end
  end

  assign res_valid = have || last;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      slot_r     <= '0;
      kept_r     <= '0;
      in_pulse_r <= 1'b0;
      run_r      <= 1'b0;
      low_r      <= 2'd0;
      integ_r    <= '0;
      width_r    <= '0;
      lead_r     <= '0;
    end else if (step_en) begin
      pos_r      <= pos_nxt;
      slot_r     <= slot_nxt;
      kept_r     <= kept_nxt;
      in_pulse_r <= in_pulse_nxt;
      run_r      <= run_nxt;
      low_r      <= low_nxt;
      integ_r    <= integ_nxt;
      width_r    <= width_nxt;
      lead_r     <= lead_nxt;
    end
  end

endmodule

// ===== hdl/pfi_out_reg.sv =====
// pfi_out_reg: result register of the pulse channel
// depends on pfi_pkg
module pfi_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  logic          res_valid,
  input  pfi_pkg::res_t res,
  output logic          out_free,
  output logic          out_valid,
  input  logic          out_stall,
  output pfi_pkg::res_t out_res
);

  logic          valid_r;
  logic          valid_nxt;
  logic          load;
  pfi_pkg::res_t res_r;

  // room when empty or when the held result leaves this cycle
  assign out_free = !valid_r || !out_stall;
  assign load     = step_en && res_valid;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== hdl/adc_pulse_finder_integrator_core.sv =====
// adc_pulse_finder_integrator_core: top level of the adc pulse finder
// depends on pfi_pkg, pfi_cfg_regs, pfi_in_reg, pfi_core, pfi_out_reg
//
// Usage:
//   in_*  : one unsigned ADC sample per transaction, windows of
//           window_length samples back to back, first sample at index 0.
//   out_* : at most one result transaction per sample: a kept pulse when a
//           pulse closes, and a window-end result on the last sample of a
//           window (carrying the open pulse if one is kept).
//   cfg_* : register writes (0 threshold, 1 window_length), taken every
//           cycle; write only while no sample is in flight.
// Timing: a sample accepted into the input register is evaluated into the
//   result register once the result side has room; out_valid rises when the
//   step yields a result. One sample per cycle is sustained while out_stall
//   is low. Step logic: one compare pair, one 23-bit add, counter updates.
// Stall: when out_stall holds a waiting result, the sample in the input
//   register waits and in_stall is raised; up to two transactions are held.
// Reset: synchronous on rst_n, clears all pulse state, empties both
//   registers and loads threshold 100 and window length 1024.
module adc_pulse_finder_integrator_core #(
  parameter int MAX_PULSES = 8,
  parameter int MAX_WINDOW = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfi_pkg::sample_t   in_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_pulse_valid,
  output logic               out_window_end,
  output pfi_pkg::idx_t      out_pulse_index,
  output pfi_pkg::lead_t     out_lead_index,
  output pfi_pkg::width_t    out_pulse_len,
  output pfi_pkg::integ_t    out_pulse_integral,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  pfi_pkg::cfg_idx_t  cfg_index,
  input  pfi_pkg::cfg_data_t cfg_data
);

  pfi_pkg::cfg_t    cfg;
  pfi_pkg::sample_t sample;
  pfi_pkg::res_t    res;
  pfi_pkg::res_t    out_res;
  logic             step_en;
  logic             out_free;
  logic             res_valid;

  // configuration registers
  pfi_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register
  pfi_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .out_free  (out_free),
    .step_en   (step_en),
    .sample    (sample)
  );

  // pulse finder step
  pfi_core #(
    .MAX_PULSES (MAX_PULSES),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .sample    (sample),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  pfi_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_pulse_valid    = out_res.pulse_valid;
  assign out_window_end     = out_res.window_end;
  assign out_pulse_index    = out_res.pulse_index;
  assign out_lead_index     = out_res.lead_index;
  assign out_pulse_len      = out_res.pulse_len;
  assign out_pulse_integral = out_res.pulse_integral;

`ifndef SYNTH
  // every result carries a pulse or marks the window end
  a_res_meaningful: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pulse_valid || out_window_end))
    else $error("result with neither pulse nor window end");

  // a bare window end carries zero pulse fields
  a_bare_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_pulse_valid) |->
      (out_pulse_len == '0 && out_pulse_integral == '0 &&
       out_lead_index == '0 && out_pulse_index == '0))
    else $error("bare window end with nonzero pulse fields");

  // kept pulses are wider than one sample
  a_kept_width: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pulse_valid) |-> (out_pulse_len > 11'd1))
    else $error("kept pulse of width one or less");

  // the input side stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");
`endif

endmodule
